// ===== src/mesh_chunk_stream_parser_unit_macros.svh =====
// assertion helper macros for the mesh chunk parser
`ifndef MESH_CHUNK_STREAM_PARSER_UNIT_MACROS_SVH
`define MESH_CHUNK_STREAM_PARSER_UNIT_MACROS_SVH
// check that a condition implies another on the same edge
`define MCSP_ASSERT_IMP(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// check that a condition implies another on the next edge
`define MCSP_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

// ===== src/mcsp_pkg.sv =====
// ---------------------------------------------------------------------------
// mcsp_pkg
// shared types and constants of the mesh chunk stream parser
// ---------------------------------------------------------------------------
package mcsp_pkg;

   localparam int BufLen = 18;

   // parse modes
   localparam logic [4:0] M_ID   = 5'd0;
   localparam logic [4:0] M_LEN  = 5'd1;
   localparam logic [4:0] M_OBJ  = 5'd2;
   localparam logic [4:0] M_SKIP = 5'd3;
   localparam logic [4:0] M_PTC  = 5'd4;
   localparam logic [4:0] M_PTS  = 5'd5;
   localparam logic [4:0] M_TCC  = 5'd6;
   localparam logic [4:0] M_TCS  = 5'd7;
   localparam logic [4:0] M_FCC  = 5'd8;
   localparam logic [4:0] M_FCS  = 5'd9;
   localparam logic [4:0] M_MATN = 5'd10;
   localparam logic [4:0] M_COL  = 5'd11;
   localparam logic [4:0] M_PROP = 5'd12;
   localparam logic [4:0] M_GRPN = 5'd13;
   localparam logic [4:0] M_GRPC = 5'd14;
   localparam logic [4:0] M_GRPL = 5'd15;
   localparam logic [4:0] M_MAP  = 5'd16;
   localparam logic [4:0] M_DONE = 5'd17;

   // record kinds
   localparam logic [3:0] K_OBJN  = 4'd0;
   localparam logic [3:0] K_POINT = 4'd1;
   localparam logic [3:0] K_TEX   = 4'd2;
   localparam logic [3:0] K_FACE  = 4'd3;
   localparam logic [3:0] K_MATN  = 4'd4;
   localparam logic [3:0] K_COL   = 4'd5;
   localparam logic [3:0] K_PROP  = 4'd6;
   localparam logic [3:0] K_GRPN  = 4'd7;
   localparam logic [3:0] K_GRPR  = 4'd8;
   localparam logic [3:0] K_OBJR  = 4'd9;
   localparam logic [3:0] K_DONE  = 4'd10;

   // value formats
   localparam logic [1:0] F_FLOAT = 2'd0;
   localparam logic [1:0] F_INT   = 2'd1;
   localparam logic [1:0] F_UNK   = 2'd2;

   // chunk tags
   localparam logic [15:0] T_MAIN  = 16'h4d4d;
   localparam logic [15:0] T_OBJ   = 16'h4000;
   localparam logic [15:0] T_MESH  = 16'h4100;
   localparam logic [15:0] T_EDIT  = 16'h3d3d;
   localparam logic [15:0] T_MATB  = 16'hAFFF;
   localparam logic [15:0] T_MAPA  = 16'hA200;
   localparam logic [15:0] T_MAPB  = 16'hA230;
   localparam logic [15:0] T_MAPC  = 16'hA33A;
   localparam logic [15:0] T_PTS   = 16'h4110;
   localparam logic [15:0] T_FACES = 16'h4120;
   localparam logic [15:0] T_GRP   = 16'h4130;
   localparam logic [15:0] T_TEX   = 16'h4140;
   localparam logic [15:0] T_MATN  = 16'hA000;
   localparam logic [15:0] T_AMB   = 16'hA010;
   localparam logic [15:0] T_DIF   = 16'hA020;
   localparam logic [15:0] T_SPC   = 16'hA030;
   localparam logic [15:0] T_SHIN  = 16'hA040;
   localparam logic [15:0] T_TRN   = 16'hA050;
   localparam logic [15:0] T_MAPN  = 16'hA300;
   localparam logic [7:0]  S_FLT   = 8'h10;
   localparam logic [7:0]  S_BYTE  = 8'h11;
   localparam logic [7:0]  S_PCT   = 8'h30;

   // one result record
   typedef struct packed {
      logic [3:0]  record_kind;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [7:0]  name_byte;
      logic [2:0]  prop_select;
      logic [1:0]  value_format;
      logic        last_in_run;
   } rec_type;

   // classified work for the back part, up to two records per byte
   typedef struct packed {
      logic    two;
      rec_type r0;
      rec_type r1;
   } work_type;

   localparam int WorkW = $bits(work_type);

endpackage

// ===== src/mcsp_front.sv =====
// ---------------------------------------------------------------------------
// mcsp_front
// byte parser: chunk headers, field capture and record building
// ---------------------------------------------------------------------------
module mcsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  logic                in_eos,
   output logic                work_valid,
   output mcsp_pkg::work_type  work
);

   logic [4:0]  mode_ff, mode_in;
   logic [15:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;
   logic [7:0]  buf_ff [mcsp_pkg::BufLen];
   logic [31:0] pos_ff, pos_in;
   logic [31:0] ecnt_ff, ecnt_in;
   logic [15:0] eexp_ff, eexp_in;
   logic [31:0] ptot_ff, ptot_in;
   logic [15:0] pbase_ff, pbase_in;
   logic [1:0]  objs_ff, objs_in;
   logic [47:0] cur_ff, cur_in;
   logic [47:0] prev_ff, prev_in;
   logic [31:0] gtot_ff, gtot_in;

   logic [31:0] pos1;
   logic        store;
   logic [7:0]  fb [mcsp_pkg::BufLen];
   logic [15:0] h16;
   logic [31:0] h32;
   logic [31:0] st;
   logic [31:0] ecnt1;
   logic [31:0] ptot1;
   logic        n0;
   logic        n1;
   mcsp_pkg::rec_type rec;

   // buffer view with the current byte merged in
   always_comb begin
      for (int i = 0; i < mcsp_pkg::BufLen; i++) begin
         fb[i] = buf_ff[i];
         if (store && pos_ff == 32'(i)) fb[i] = in_byte;
      end
   end

   assign pos1  = pos_ff + 32'd1;
   assign store = in_valid && pos_ff < 32'(mcsp_pkg::BufLen) && mode_ff != mcsp_pkg::M_SKIP
                  && mode_ff != mcsp_pkg::M_DONE;
   assign h16   = {fb[1], fb[0]};
   assign h32   = {fb[3], fb[2], fb[1], fb[0]};
   assign ecnt1 = ecnt_ff + 32'd1;
   assign ptot1 = ptot_ff + 32'd1;

   // main parse step
   always_comb begin
      mode_in = mode_ff; tag_in = tag_ff; size_in = size_ff; pos_in = pos_ff;
      ecnt_in = ecnt_ff; eexp_in = eexp_ff; ptot_in = ptot_ff; pbase_in = pbase_ff;
      objs_in = objs_ff; cur_in = cur_ff; prev_in = prev_ff; gtot_in = gtot_ff;
      rec = '0; n0 = 1'b0; st = cur_ff[31:0];
      if (mode_ff != mcsp_pkg::M_SKIP && mode_ff != mcsp_pkg::M_DONE) pos_in = pos1;
      unique case (mode_ff)
         mcsp_pkg::M_ID: begin
            if (pos1 == 32'd2) begin
               tag_in = h16; pos_in = '0; mode_in = mcsp_pkg::M_LEN;
            end
         end
         mcsp_pkg::M_LEN: begin
            if (pos1 == 32'd4) begin
               size_in = h32; pos_in = '0;
               unique case (tag_ff)
                  mcsp_pkg::T_MAIN, mcsp_pkg::T_MESH, mcsp_pkg::T_EDIT, mcsp_pkg::T_MATB,
                  mcsp_pkg::T_MAPA, mcsp_pkg::T_MAPB, mcsp_pkg::T_MAPC:
                     mode_in = mcsp_pkg::M_ID;
                  mcsp_pkg::T_OBJ:   mode_in = mcsp_pkg::M_OBJ;
                  mcsp_pkg::T_PTS:   mode_in = mcsp_pkg::M_PTC;
                  mcsp_pkg::T_FACES: mode_in = mcsp_pkg::M_FCC;
                  mcsp_pkg::T_GRP:   mode_in = mcsp_pkg::M_GRPN;
                  mcsp_pkg::T_TEX:   mode_in = mcsp_pkg::M_TCC;
                  mcsp_pkg::T_MATN:  mode_in = mcsp_pkg::M_MATN;
                  mcsp_pkg::T_AMB, mcsp_pkg::T_DIF, mcsp_pkg::T_SPC:
                     mode_in = (h32 <= 32'd6) ? mcsp_pkg::M_ID : mcsp_pkg::M_COL;
                  mcsp_pkg::T_SHIN, mcsp_pkg::T_TRN:
                     mode_in = (h32 <= 32'd6) ? mcsp_pkg::M_ID : mcsp_pkg::M_PROP;
                  mcsp_pkg::T_MAPN:  mode_in = mcsp_pkg::M_MAP;
                  default: begin
                     ecnt_in = 32'd6;
                     mode_in = (h32 <= 32'd6) ? mcsp_pkg::M_ID : mcsp_pkg::M_SKIP;
                  end
               endcase
            end
         end
         mcsp_pkg::M_OBJ: begin
            n0 = 1'b1; rec.record_kind = mcsp_pkg::K_OBJN; rec.name_byte = in_byte;
            if (in_byte == 8'd0) begin
               prev_in = cur_ff; cur_in = '0;
               if (objs_ff < 2'd2) objs_in = objs_ff + 2'd1;
               mode_in = mcsp_pkg::M_ID; pos_in = '0;
            end
         end
         mcsp_pkg::M_PTC, mcsp_pkg::M_TCC: begin
            if (pos1 == 32'd2) begin
               eexp_in = h16; pos_in = '0; ecnt_in = '0;
               if (h16 == 16'd0) begin
                  if (mode_ff == mcsp_pkg::M_PTC) pbase_in = ptot_ff[15:0];
                  mode_in = mcsp_pkg::M_ID;
               end else begin
                  mode_in = (mode_ff == mcsp_pkg::M_PTC) ? mcsp_pkg::M_PTS : mcsp_pkg::M_TCS;
               end
            end
         end
         mcsp_pkg::M_PTS: begin
            if (pos1 == 32'd12) begin
               n0 = 1'b1; rec.record_kind = mcsp_pkg::K_POINT;
               rec.word_a = {fb[3], fb[2], fb[1], fb[0]};
               rec.word_b = {fb[7], fb[6], fb[5], fb[4]};
               rec.word_c = {fb[11], fb[10], fb[9], fb[8]};
               ptot_in = ptot1; ecnt_in = ecnt1; pos_in = '0;
               if (ecnt1 >= {16'd0, eexp_ff}) begin
                  mode_in = mcsp_pkg::M_ID;
                  pbase_in = ptot1[15:0] - eexp_ff;
               end
            end
         end
         mcsp_pkg::M_TCS: begin
            if (pos1 == 32'd8) begin
               n0 = 1'b1; rec.record_kind = mcsp_pkg::K_TEX;
               rec.word_a = {fb[3], fb[2], fb[1], fb[0]};
               rec.word_b = {fb[7], fb[6], fb[5], fb[4]};
               ecnt_in = ecnt1; pos_in = '0;
               if (ecnt1 >= {16'd0, eexp_ff}) mode_in = mcsp_pkg::M_ID;
            end
         end
         mcsp_pkg::M_FCC: begin
            if (pos1 == 32'd2) begin
               eexp_in = h16;
               if (objs_ff > 2'd1) st = prev_ff[31:0] + {16'd0, prev_ff[47:32]};
               cur_in = {h16, st};
               n0 = 1'b1; rec.record_kind = mcsp_pkg::K_OBJR;
               rec.word_a = st; rec.word_b = {16'd0, h16};
               pos_in = '0; ecnt_in = '0;
               mode_in = (h16 == 16'd0) ? mcsp_pkg::M_ID : mcsp_pkg::M_FCS;
            end
         end
         mcsp_pkg::M_FCS: begin
            if (pos1 == 32'd8) begin
               n0 = 1'b1; rec.record_kind = mcsp_pkg::K_FACE;
               rec.word_a = {16'd0, {fb[1], fb[0]} + pbase_ff};
               rec.word_b = {16'd0, {fb[3], fb[2]} + pbase_ff};
               rec.word_c = {16'd0, {fb[5], fb[4]} + pbase_ff};
               ecnt_in = ecnt1; pos_in = '0;
               if (ecnt1 >= {16'd0, eexp_ff}) mode_in = mcsp_pkg::M_ID;
            end
         end
         mcsp_pkg::M_MATN, mcsp_pkg::M_GRPN, mcsp_pkg::M_MAP: begin
            if (mode_ff != mcsp_pkg::M_MAP) begin
               n0 = 1'b1;
               rec.record_kind = (mode_ff == mcsp_pkg::M_MATN) ? mcsp_pkg::K_MATN
                                                                : mcsp_pkg::K_GRPN;
               rec.name_byte = in_byte;
            end
            if (in_byte == 8'd0) begin
               mode_in = (mode_ff == mcsp_pkg::M_GRPN) ? mcsp_pkg::M_GRPC : mcsp_pkg::M_ID;
               pos_in = '0;
            end
         end
         mcsp_pkg::M_COL, mcsp_pkg::M_PROP: begin
            if (pos1 == size_ff - 32'd6) begin
               n0 = 1'b1; rec.value_format = mcsp_pkg::F_UNK;
               if (mode_ff == mcsp_pkg::M_COL) begin
                  rec.record_kind = mcsp_pkg::K_COL;
                  rec.prop_select = (tag_ff == mcsp_pkg::T_AMB) ? 3'd0 :
                                    (tag_ff == mcsp_pkg::T_DIF) ? 3'd1 : 3'd2;
                  if (fb[0] == mcsp_pkg::S_FLT) begin
                     rec.word_a = {fb[9], fb[8], fb[7], fb[6]};
                     rec.word_b = {fb[13], fb[12], fb[11], fb[10]};
                     rec.word_c = {fb[17], fb[16], fb[15], fb[14]};
                     rec.value_format = mcsp_pkg::F_FLOAT;
                  end else if (fb[0] == mcsp_pkg::S_BYTE) begin
                     rec.word_a = {24'd0, fb[6]};
                     rec.word_b = {24'd0, fb[7]};
                     rec.word_c = {24'd0, fb[8]};
                     rec.value_format = mcsp_pkg::F_INT;
                  end
               end else begin
                  rec.record_kind = mcsp_pkg::K_PROP;
                  rec.prop_select = (tag_ff == mcsp_pkg::T_SHIN) ? 3'd3 : 3'd4;
                  if (fb[0] == mcsp_pkg::S_PCT) begin
                     rec.word_a = {16'd0, fb[7], fb[6]};
                     rec.value_format = mcsp_pkg::F_INT;
                  end else if (fb[0] == mcsp_pkg::S_BYTE) begin
                     rec.word_a = {fb[9], fb[8], fb[7], fb[6]};
                     rec.value_format = mcsp_pkg::F_FLOAT;
                  end
               end
               mode_in = mcsp_pkg::M_ID; pos_in = '0;
            end
         end
         mcsp_pkg::M_GRPC: begin
            if (pos1 == 32'd2) begin
               eexp_in = h16;
               n0 = 1'b1; rec.record_kind = mcsp_pkg::K_GRPR;
               rec.word_a = gtot_ff; rec.word_b = {16'd0, h16};
               gtot_in = gtot_ff + {16'd0, h16};
               pos_in = '0; ecnt_in = '0;
               mode_in = (h16 == 16'd0) ? mcsp_pkg::M_ID : mcsp_pkg::M_GRPL;
            end
         end
         mcsp_pkg::M_GRPL: begin
            if (pos1 == 32'd2) begin
               ecnt_in = ecnt1; pos_in = '0;
               if (ecnt1 >= {16'd0, eexp_ff}) mode_in = mcsp_pkg::M_ID;
            end
         end
         mcsp_pkg::M_SKIP: begin
            ecnt_in = ecnt1;
            if (ecnt1 >= size_ff) mode_in = mcsp_pkg::M_ID;
         end
         default: ;
      endcase
      if (in_eos) mode_in = mcsp_pkg::M_DONE;
   end

   // pack records: done record rides second or alone
   always_comb begin
      n1 = in_eos;
      work = '0;
      work.two = n0 && n1;
      if (n0) begin
         work.r0 = rec;
         work.r0.last_in_run = !n1;
         work.r1.record_kind = mcsp_pkg::K_DONE;
         work.r1.last_in_run = 1'b1;
      end else begin
         work.r0.record_kind = mcsp_pkg::K_DONE;
         work.r0.last_in_run = 1'b1;
      end
   end
   assign work_valid = in_valid && (n0 || n1);

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mcsp_pkg::M_ID; tag_ff <= '0; size_ff <= '0; pos_ff <= '0;
         ecnt_ff <= '0; eexp_ff <= '0; ptot_ff <= '0; pbase_ff <= '0; objs_ff <= '0;
         cur_ff <= '0; prev_ff <= '0; gtot_ff <= '0;
      end else if (in_valid && mode_ff != mcsp_pkg::M_DONE) begin
         mode_ff <= mode_in; tag_ff <= tag_in; size_ff <= size_in; pos_ff <= pos_in;
         ecnt_ff <= ecnt_in; eexp_ff <= eexp_in; ptot_ff <= ptot_in; pbase_ff <= pbase_in;
         objs_ff <= objs_in; cur_ff <= cur_in; prev_ff <= prev_in; gtot_ff <= gtot_in;
      end
   end

   // capture buffer
   always_ff @(posedge clock) begin
      for (int i = 0; i < mcsp_pkg::BufLen; i++) begin
         if (store && pos_ff == 32'(i)) buf_ff[i] <= in_byte;
      end
   end

endmodule

// ===== src/mcsp_queue.sv =====
// ---------------------------------------------------------------------------
// mcsp_queue
// short work queue between parser and record sender
// ---------------------------------------------------------------------------
`include "mesh_chunk_stream_parser_unit_macros.svh"
module mcsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  mcsp_pkg::work_type  wr_data,
   output logic                full,
   input  logic                rd_en,
   output logic                empty,
   output mcsp_pkg::work_type  rd_data
);

   mcsp_pkg::work_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full    = cnt_ff == 3'd4;
   assign empty   = cnt_ff == 3'd0;
   assign rd_data = mem_ff[rp_ff];

   // storage
   always_ff @(posedge clock) begin
      if (wr_en && !full) mem_ff[wp_ff] <= wr_data;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en && !full) wp_ff <= wp_ff + 2'd1;
         if (rd_en && !empty) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'((wr_en && !full) ? 1 : 0) - 3'((rd_en && !empty) ? 1 : 0);
      end
   end

   `MCSP_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 3'd4)
   `MCSP_ASSERT_NEXT(a_fill, clock, reset, wr_en && !full && !rd_en, !empty)
   `MCSP_ASSERT_IMP(a_ptr, clock, reset, empty || full, wp_ff == rp_ff)

endmodule

// ===== src/mcsp_back.sv =====
// ---------------------------------------------------------------------------
// mcsp_back
// record sender: splits one or two records and holds them for the consumer
// ---------------------------------------------------------------------------
`include "mesh_chunk_stream_parser_unit_macros.svh"
module mcsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  mcsp_pkg::work_type  q_data,
   output logic                q_pop,
   output logic                out_empty,
   input  logic                out_pop,
   output mcsp_pkg::rec_type   out_rec
);

   logic half_ff;
   logic last_of_entry;

   assign out_empty     = q_empty;
   assign out_rec       = (q_data.two && half_ff) ? q_data.r1 : q_data.r0;
   assign last_of_entry = !q_data.two || half_ff;
   assign q_pop         = out_pop && !q_empty && last_of_entry;

   // second-record selector
   always_ff @(posedge clock) begin
      if (reset) half_ff <= 1'b0;
      else if (out_pop && !q_empty) half_ff <= !last_of_entry;
   end

   `MCSP_ASSERT_IMP(a_half, clock, reset, half_ff, !q_empty && q_data.two)
   `MCSP_ASSERT_IMP(a_last, clock, reset, q_pop, out_rec.last_in_run)

endmodule

// ===== src/mesh_chunk_stream_parser_unit.sv =====
// ---------------------------------------------------------------------------
// mesh_chunk_stream_parser_unit
// mesh file chunk parser; while full is low, it takes one byte per cycle
// ---------------------------------------------------------------------------
// usage:
//  - bytes go in on req_data_byte with req_end_of_stream on the last one;
//    a word is taken when push is high and full is low
//  - records come out queue-style: while rsp empty is low the oldest record
//    is on the rsp_ ports, taken when pop is high
//  - the parser takes one byte every cycle while full is low; a byte makes
//    zero, one or two records, written to a four-entry work queue at the
//    same edge that takes the byte
//  - a record is stored in the work queue and shows on the rsp_ ports once older records have left
//  - throughput: one record per cycle out while empty is low and pop is high; a byte with two records takes
//    two pops to leave the queue
//  - a stalled consumer fills the queue, then full rises and input waits
//  - reset clears the parser to read a chunk id and empties the queue
//  - full is held high for bytes while the queue cannot take a word
// ---------------------------------------------------------------------------
module mesh_chunk_stream_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_record_kind,
   output logic [31:0] rsp_word_a,
   output logic [31:0] rsp_word_b,
   output logic [31:0] rsp_word_c,
   output logic [7:0]  rsp_name_byte,
   output logic [2:0]  rsp_prop_select,
   output logic [1:0]  rsp_value_format,
   output logic        rsp_last_in_run
);

   logic               acc;
   logic               wv;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;
   mcsp_pkg::work_type w;
   mcsp_pkg::work_type qd;
   mcsp_pkg::rec_type  r;

   assign full = q_full;
   assign acc  = push && !q_full;

   // front parser
   mcsp_front u_front (
      .clock(clock), .reset(reset), .in_valid(acc), .in_byte(req_data_byte),
      .in_eos(req_end_of_stream), .work_valid(wv), .work(w)
   );

   // decoupling queue
   mcsp_queue u_queue (
      .clock(clock), .reset(reset), .wr_en(wv), .wr_data(w), .full(q_full),
      .rd_en(q_pop), .empty(q_empty), .rd_data(qd)
   );

   // record sender
   mcsp_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(qd), .q_pop(q_pop),
      .out_empty(empty), .out_pop(pop), .out_rec(r)
   );

   assign rsp_record_kind  = r.record_kind;
   assign rsp_word_a       = r.word_a;
   assign rsp_word_b       = r.word_b;
   assign rsp_word_c       = r.word_c;
   assign rsp_name_byte    = r.name_byte;
   assign rsp_prop_select  = r.prop_select;
   assign rsp_value_format = r.value_format;
   assign rsp_last_in_run  = r.last_in_run;

endmodule
